/* rtl/ssac_pkg.sv */
// Shared types, codes and sizes for the swap slot allocator with page checksum.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ssac_pkg;

   localparam int DEF_SLOT_COUNT = 1024;

   localparam int OP_W   = 2;
   localparam int SLOT_W = 10;
   localparam int SUM_W  = 32;
   localparam int STAT_W = 2;

   // Request operations.
   localparam logic [OP_W-1:0] OP_SWAP_OUT = 2'd0;
   localparam logic [OP_W-1:0] OP_SWAP_IN  = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE     = 2'd2;

   // Response status codes.
   localparam logic [STAT_W-1:0] ST_STORED   = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_MATCH    = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd3;

   // Commands handed from the front end to the table engine.
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_CHECK  = 2'd1;
   localparam logic [1:0] CMD_FREE   = 2'd2;
   localparam logic [1:0] CMD_REJECT = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [SUM_W-1:0]  sum;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

/* rtl/ssac_front.sv */
// Front end: takes request beats, keeps the running page sum and turns page ends
// and frees into table commands. Depends on ssac_pkg.
`timescale 1ns / 1ps

module ssac_front #(
   parameter int SLOT_COUNT = ssac_pkg::DEF_SLOT_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ssac_pkg::OP_W-1:0]     req_op,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   input  logic [ssac_pkg::SLOT_W-1:0]   req_slot,
   input  ssac_pkg::fifo_stat_type       q_stat,
   input  ssac_pkg::back_stat_type       b_stat,
   output logic                          push,
   output ssac_pkg::cmd_type             push_cmd
);
   import ssac_pkg::*;

   logic [SUM_W-1:0] run_sum_ff, run_sum_in;
   logic [SUM_W-1:0] byte_sum;
   logic             accept;
   logic             slot_ok;

   assign busy     = reset | b_stat.clearing | q_stat.full;
   assign accept   = start & ~busy;
   assign slot_ok  = 32'(req_slot) < 32'(SLOT_COUNT);
   assign byte_sum = run_sum_ff + {{(SUM_W-8){req_data_byte[7]}}, req_data_byte};

   always_comb begin
      run_sum_in    = run_sum_ff;
      push          = 1'b0;
      push_cmd.kind = CMD_ALLOC;
      push_cmd.slot = req_slot;
      push_cmd.sum  = byte_sum;
      if (accept) begin
         case (req_op)
            OP_SWAP_OUT, OP_SWAP_IN: begin
               if (req_last_byte) begin
                  run_sum_in = '0;
                  push       = 1'b1;
                  if (req_op == OP_SWAP_OUT) begin
                     push_cmd.kind = CMD_ALLOC;
                  end else if (slot_ok) begin
                     push_cmd.kind = CMD_CHECK;
                  end else begin
                     push_cmd.kind = CMD_REJECT;
                  end
               end else begin
                  run_sum_in = byte_sum;
               end
            end
            OP_FREE: begin
               push          = slot_ok;
               push_cmd.kind = CMD_FREE;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff <= '0;
      end else begin
         run_sum_ff <= run_sum_in;
      end
   end

endmodule

/* rtl/ssac_fifo.sv */
// Short command queue between the front end and the table engine.
// Depends on ssac_pkg for the command type and queue size.
`timescale 1ns / 1ps

module ssac_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ssac_pkg::cmd_type       push_cmd,
   input  logic                    pop,
   output ssac_pkg::cmd_type       head_cmd,
   output ssac_pkg::fifo_stat_type stat
);
   import ssac_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign stat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign stat.empty = count_ff == '0;
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full))
      else $error("command queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && stat.empty))
      else $error("command queue read while empty");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("command queue count did not follow a lone write");
`endif

endmodule

/* rtl/ssac_back.sv */
// Table engine: owns the free-list link memory, the per-slot checksum memory and
// the free head, executes queued commands and drives the response. Depends on ssac_pkg.
`timescale 1ns / 1ps

module ssac_back #(
   parameter int SLOT_COUNT = ssac_pkg::DEF_SLOT_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ssac_pkg::cmd_type                 head_cmd,
   input  ssac_pkg::fifo_stat_type           q_stat,
   output logic                              pop,
   output ssac_pkg::back_stat_type           b_stat,
   output logic                              rsp_strobe,
   output logic [ssac_pkg::STAT_W-1:0]       rsp_status,
   output logic [ssac_pkg::SLOT_W-1:0]       rsp_slot_out,
   output logic signed [ssac_pkg::SUM_W-1:0] rsp_page_sum
);
   import ssac_pkg::*;

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int LINK_W = $clog2(SLOT_COUNT + 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [LINK_W-1:0] link_mem [SLOT_COUNT];
   logic [SUM_W-1:0]  sum_mem  [SLOT_COUNT];

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [LINK_W-1:0] head_ff, head_in;
   cmd_type           cmd_ff, cmd_in;
   logic [LINK_W-1:0] link_rd_ff;
   logic [SUM_W-1:0]  sum_rd_ff;

   logic              strobe_ff, strobe_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SUM_W-1:0]  psum_ff, psum_in;

   logic              link_we, sum_we;
   logic [IDX_W-1:0]  link_wa, sum_wa;
   logic [LINK_W-1:0] link_wd;
   logic [SUM_W-1:0]  sum_wd;
   logic              pool_empty;

   assign pool_empty      = head_ff == LINK_W'(SLOT_COUNT);
   assign pop             = (state_ff == S_IDLE) && !q_stat.empty;
   assign b_stat.clearing = state_ff == S_CLEAR;

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_slot_out = slot_ff;
   assign rsp_page_sum = psum_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      head_in   = head_ff;
      cmd_in    = cmd_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      slot_in   = slot_ff;
      psum_in   = psum_ff;
      link_we   = 1'b0;
      link_wa   = IDX_W'(cmd_ff.slot);
      link_wd   = head_ff;
      sum_we    = 1'b0;
      sum_wa    = IDX_W'(head_ff);
      sum_wd    = cmd_ff.sum;
      case (state_ff)
         S_CLEAR: begin
            // Rebuild the initial chain: entry i links to i+1, the last to null.
            link_we = 1'b1;
            link_wa = clr_ff;
            link_wd = LINK_W'(clr_ff) + LINK_W'(1);
            sum_we  = 1'b1;
            sum_wa  = clr_ff;
            sum_wd  = '0;
            if (clr_ff == IDX_W'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (pop) begin
               cmd_in   = head_cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            psum_in  = cmd_ff.sum;
            slot_in  = cmd_ff.slot;
            case (cmd_ff.kind)
               CMD_ALLOC: begin
                  strobe_in = 1'b1;
                  if (pool_empty) begin
                     status_in = ST_FULL;
                     slot_in   = '0;
                  end else begin
                     status_in = ST_STORED;
                     slot_in   = SLOT_W'(head_ff);
                     sum_we    = 1'b1;
                     head_in   = link_rd_ff;
                  end
               end
               CMD_CHECK: begin
                  strobe_in = 1'b1;
                  if (sum_rd_ff == cmd_ff.sum) begin
                     status_in = ST_MATCH;
                     link_we   = 1'b1;
                     head_in   = LINK_W'(cmd_ff.slot);
                  end else begin
                     status_in = ST_MISMATCH;
                  end
               end
               CMD_FREE: begin
                  link_we = 1'b1;
                  head_in = LINK_W'(cmd_ff.slot);
               end
               default: begin
                  strobe_in = 1'b1;
                  status_in = ST_MISMATCH;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         head_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         head_ff   <= head_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      psum_ff   <= psum_in;
   end

   // The read taken in the idle cycle is what the following execute cycle uses.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[IDX_W'(head_ff)];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[IDX_W'(head_cmd.slot)];
   end

`ifndef SYNTHESIS
   a_strobe_from_exec: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff) == S_EXEC)
      else $error("response issued outside an execute cycle");
   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LINK_W'(SLOT_COUNT))
      else $error("free head beyond null");
   a_alloc_follows_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && cmd_ff.kind == CMD_ALLOC && !pool_empty)
      |=> head_ff == $past(link_rd_ff))
      else $error("allocation did not advance the free head along its link");
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !pop && !strobe_ff)
      else $error("command taken or response issued during clearing pass");
`endif

endmodule

/* rtl/swap_slot_allocator_checksum_unit.sv */
// Top level of the swap slot allocator with per-slot page checksum.
// Depends on ssac_pkg, ssac_front, ssac_fifo and ssac_back.
`timescale 1ns / 1ps

//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------
//  request   | req_op, req_data_byte, req_last_byte,        | beat taken when start is
//            | req_slot                                     | high and busy is low
//  response  | rsp_status, rsp_slot_out, rsp_page_sum       | one-cycle rsp_strobe
//
// Page bytes are taken one per cycle while busy is low. A last byte, or a free of a
// slot below SLOT_COUNT, places a command in a four-entry queue; the table engine
// takes one command at a time (a memory read in idle, then execute) and pops the
// next only back in idle; the response is registered after execute. busy is high in
// reset, during the clearing pass and while the queue is full. After reset the engine
// rebuilds the link and checksum memories, one entry per cycle, with busy high.
module swap_slot_allocator_checksum_unit #(
   parameter int SLOT_COUNT = ssac_pkg::DEF_SLOT_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ssac_pkg::OP_W-1:0]         req_op,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   input  logic [ssac_pkg::SLOT_W-1:0]       req_slot,
   output logic                              rsp_strobe,
   output logic [ssac_pkg::STAT_W-1:0]       rsp_status,
   output logic [ssac_pkg::SLOT_W-1:0]       rsp_slot_out,
   output logic signed [ssac_pkg::SUM_W-1:0] rsp_page_sum
);
   import ssac_pkg::*;

   logic          push, pop;
   cmd_type       push_cmd, head_cmd;
   fifo_stat_type q_stat;
   back_stat_type b_stat;

   ssac_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_slot      (req_slot),
      .q_stat        (q_stat),
      .b_stat        (b_stat),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   ssac_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   ssac_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .q_stat       (q_stat),
      .pop          (pop),
      .b_stat       (b_stat),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_slot_out (rsp_slot_out),
      .rsp_page_sum (rsp_page_sum)
   );

endmodule
